FILE: hw/rtl/hlcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlcb_pkg
// Types and constants for the heatmap layer color blend unit.
// ----------------------------------------------------------------------------
package hlcb_pkg;

    localparam int LEVEL_W   = 16;
    localparam int FS_W      = 16;
    localparam int ALPHA_W   = 8;
    localparam int CHAN_W    = 8;
    localparam int NUM_LAYER = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DW    = 16;

    localparam logic [FS_W-1:0]    FULL_SCALE_RST = 16'd30720;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX_RST  = 8'd200;

    // layer colors, [layer][r,g,b]: food, home, danger
    localparam logic [CHAN_W-1:0] LAYER_RGB [NUM_LAYER][3] = '{
        '{8'd60,  8'd220, 8'd130},
        '{8'd90,  8'd150, 8'd255},
        '{8'd235, 8'd70,  8'd70}
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE_FOOD   = 3'd0,
        CFG_ENABLE_HOME   = 3'd1,
        CFG_ENABLE_DANGER = 3'd2,
        CFG_FULL_SCALE    = 3'd3,
        CFG_ALPHA_MAX     = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [LEVEL_W-1:0] food_level;
        logic [LEVEL_W-1:0] home_level;
        logic [LEVEL_W-1:0] danger_level;
    } t_cell;

    typedef struct packed {
        logic [ALPHA_W-1:0] out_alpha;
        logic [CHAN_W-1:0]  out_red;
        logic [CHAN_W-1:0]  out_green;
        logic [CHAN_W-1:0]  out_blue;
    } t_pixel;

endpackage

FILE: hw/rtl/heatmap_layer_color_blend_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heatmap_layer_color_blend_unit
// Blends three layer intensities of a grid cell into one RGBA pixel.
// ----------------------------------------------------------------------------
// One cell is taken every clock; busy never rises. Each pixel is shown on
// o_result with o_strobe for one cycle. The pipeline holds the two restoring
// dividers laid out as stages: one stage per weight fraction bit and one
// stage per color bit. Four more stages hold the input register, the
// saturation check, the weight sum and the weighted sums. The receiver cannot
// stall, so a pixel must be taken in the cycle it is shown.
// Configuration is written through the cfg port, which is always ready, and
// must only change while no cell is in flight.
// ----------------------------------------------------------------------------
module heatmap_layer_color_blend_unit
    import hlcb_pkg::*;
#(
    parameter int WEIGHT_FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_cell                i_cell,
    output logic                 o_strobe,
    output t_pixel               o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DW-1:0]    i_cfg_data
);

    localparam int F   = WEIGHT_FRAC_BITS;
    localparam int DW  = LEVEL_W + 1;
    localparam int WW  = F + 1;
    localparam int TW  = F + 2;
    localparam int AW  = F + 10;
    localparam int PW  = WW + ALPHA_W;
    localparam int LAT = F + 12;

    localparam logic [WW-1:0] W_ONE = {1'b1, {F{1'b0}}};

    // ---------------- configuration ----------------
    logic [NUM_LAYER-1:0] r_en;
    logic [FS_W-1:0]      r_full_scale;
    logic [ALPHA_W-1:0]   r_alpha_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en         <= '0;
            r_full_scale <= FULL_SCALE_RST;
            r_alpha_max  <= ALPHA_MAX_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE_FOOD:   r_en[0]      <= i_cfg_data[0];
                CFG_ENABLE_HOME:   r_en[1]      <= i_cfg_data[0];
                CFG_ENABLE_DANGER: r_en[2]      <= i_cfg_data[0];
                CFG_FULL_SCALE:    r_full_scale <= i_cfg_data[FS_W-1:0];
                CFG_ALPHA_MAX:     r_alpha_max  <= i_cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign busy        = 1'b0;

    logic [DW-1:0] fs_ext;
    assign fs_ext = {{(DW-FS_W){1'b0}}, r_full_scale};

    // ---------------- input register ----------------
    logic               r_in_valid;
    logic [LEVEL_W-1:0] r_lvl [NUM_LAYER];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lvl[0] <= i_cell.food_level;
        r_lvl[1] <= i_cell.home_level;
        r_lvl[2] <= i_cell.danger_level;
    end

    // ---------------- weight divider ----------------
    // stage 0: saturation check; stages 1..F: one quotient bit each
    logic                 r_ws_valid [0:F];
    logic [NUM_LAYER-1:0] r_ws_sat   [0:F];
    logic [DW-1:0]        r_ws_rem   [0:F][NUM_LAYER];
    logic [F-1:0]         r_ws_q     [0:F][NUM_LAYER];

    logic [NUM_LAYER-1:0] n_ws_sat;
    logic [DW-1:0]        n_ws_lvl [NUM_LAYER];

    always_comb begin
        for (int k = 0; k < NUM_LAYER; k++) begin
            n_ws_lvl[k] = {1'b0, r_lvl[k]};
            if (r_full_scale == '0) begin
                n_ws_sat[k] = (r_lvl[k] != '0);
            end else begin
                n_ws_sat[k] = (n_ws_lvl[k] >= fs_ext);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws_valid[0] <= 1'b0;
        end else begin
            r_ws_valid[0] <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ws_sat[0] <= n_ws_sat;
        for (int k = 0; k < NUM_LAYER; k++) begin
            r_ws_rem[0][k] <= n_ws_lvl[k];
            r_ws_q[0][k]   <= '0;
        end
    end

    for (genvar j = 1; j <= F; j++) begin : g_wdiv
        logic [DW-1:0] n_sh  [NUM_LAYER];
        logic [DW-1:0] n_rem [NUM_LAYER];
        logic [F-1:0]  n_q   [NUM_LAYER];

        always_comb begin
            for (int k = 0; k < NUM_LAYER; k++) begin
                n_sh[k] = {r_ws_rem[j-1][k][DW-2:0], 1'b0};
                if (n_sh[k] >= fs_ext) begin
                    n_rem[k] = n_sh[k] - fs_ext;
                    n_q[k]   = {r_ws_q[j-1][k][F-2:0], 1'b1};
                end else begin
                    n_rem[k] = n_sh[k];
                    n_q[k]   = {r_ws_q[j-1][k][F-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_ws_valid[j] <= 1'b0;
            end else begin
                r_ws_valid[j] <= r_ws_valid[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_ws_sat[j] <= r_ws_sat[j-1];
            for (int k = 0; k < NUM_LAYER; k++) begin
                r_ws_rem[j][k] <= n_rem[k];
                r_ws_q[j][k]   <= n_q[k];
            end
        end
    end

    // ---------------- weights and total ----------------
    logic          r_w_valid;
    logic [WW-1:0] r_w [NUM_LAYER];
    logic [TW-1:0] r_w_tot;
    logic [WW-1:0] n_w [NUM_LAYER];
    logic [TW-1:0] n_w_tot;

    // zero full scale: only a nonzero level counts, and then as one
    always_comb begin
        n_w_tot = '0;
        for (int k = 0; k < NUM_LAYER; k++) begin
            if (!r_en[k]) begin
                n_w[k] = '0;
            end else if (r_ws_sat[F][k]) begin
                n_w[k] = W_ONE;
            end else if (r_full_scale == '0) begin
                n_w[k] = '0;
            end else begin
                n_w[k] = {1'b0, r_ws_q[F][k]};
            end
            n_w_tot = n_w_tot + TW'(n_w[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_valid <= 1'b0;
        end else begin
            r_w_valid <= r_ws_valid[F];
        end
    end

    always_ff @(posedge i_clk) begin
        r_w     <= n_w;
        r_w_tot <= n_w_tot;
    end

    // ---------------- weighted sums and alpha ----------------
    localparam int DS = CHAN_W;

    logic               r_d_valid [0:DS];
    logic               r_d_zero  [0:DS];
    logic [TW-1:0]      r_d_tot   [0:DS];
    logic [ALPHA_W-1:0] r_d_alpha [0:DS];
    logic [AW-1:0]      r_d_rem   [0:DS][3];
    logic [CHAN_W-1:0]  r_d_q     [0:DS][3];

    logic [AW-1:0] n_acc [3];
    logic [WW-1:0] n_cap;
    logic [PW-1:0] n_aprod;

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            n_acc[c] = '0;
            for (int k = 0; k < NUM_LAYER; k++) begin
                n_acc[c] = n_acc[c] + AW'(LAYER_RGB[k][c]) * AW'(r_w[k]);
            end
        end
        n_cap   = (r_w_tot >= TW'(W_ONE)) ? W_ONE : r_w_tot[WW-1:0];
        n_aprod = PW'(n_cap) * PW'(r_alpha_max);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid[0] <= 1'b0;
        end else begin
            r_d_valid[0] <= r_w_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_zero[0]  <= (r_w_tot == '0);
        r_d_tot[0]   <= r_w_tot;
        r_d_alpha[0] <= n_aprod[F +: ALPHA_W];
        for (int c = 0; c < 3; c++) begin
            r_d_rem[0][c] <= n_acc[c];
            r_d_q[0][c]   <= '0;
        end
    end

    // ---------------- color divider, MSB first ----------------
    for (genvar i = 1; i <= DS; i++) begin : g_cdiv
        logic [AW-1:0]     n_div;
        logic [AW-1:0]     n_rem [3];
        logic [CHAN_W-1:0] n_q   [3];

        always_comb begin
            n_div = AW'(r_d_tot[i-1]) << (DS - i);
            for (int c = 0; c < 3; c++) begin
                if (!r_d_zero[i-1] && (r_d_rem[i-1][c] >= n_div)) begin
                    n_rem[c] = r_d_rem[i-1][c] - n_div;
                    n_q[c]   = {r_d_q[i-1][c][CHAN_W-2:0], 1'b1};
                end else begin
                    n_rem[c] = r_d_rem[i-1][c];
                    n_q[c]   = {r_d_q[i-1][c][CHAN_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_valid[i] <= 1'b0;
            end else begin
                r_d_valid[i] <= r_d_valid[i-1];
            end
        end

        always_ff @(posedge i_clk) begin
            r_d_zero[i]  <= r_d_zero[i-1];
            r_d_tot[i]   <= r_d_tot[i-1];
            r_d_alpha[i] <= r_d_alpha[i-1];
            for (int c = 0; c < 3; c++) begin
                r_d_rem[i][c] <= n_rem[c];
                r_d_q[i][c]   <= n_q[c];
            end
        end
    end

    assign o_strobe           = r_d_valid[DS];
    assign o_result.out_alpha = r_d_alpha[DS];
    assign o_result.out_red   = r_d_q[DS][0];
    assign o_result.out_green = r_d_q[DS][1];
    assign o_result.out_blue  = r_d_q[DS][2];

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_strobe)
        else $error("taken cell produced no pixel");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start, LAT))
        else $error("pixel without a taken cell");

    a_blend_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.out_alpha != '0) |-> (o_result.out_red >= 8'd60))
        else $error("visible pixel with red below the lowest layer red");

endmodule
